[rtl/ipsb_pkg.sv]
// Shared constants, types and helper functions of the isotropic power spectrum binner.
`default_nettype none
package ipsb_pkg;
  localparam int GridSize  = 64;
  localparam int HalfN     = GridSize / 2;
  localparam int NumShells = HalfN + 1;
  localparam int ReportN   = (HalfN < 32) ? HalfN : 32;
  localparam int IdxW      = 6;
  localparam int FoldW     = $clog2(HalfN + 1);
  localparam int MagW      = $clog2(3 * HalfN * HalfN + 1);
  localparam int ShellW    = $clog2(NumShells);
  localparam int SqW       = 31;
  localparam int PowW      = 33;
  localparam int SumW      = 51;
  localparam int CntW      = 19;
  localparam int BinW      = SumW + CntW;
  localparam int MeanW     = 33;
  localparam int OutShW    = 5;
  localparam int DivCntW   = $clog2(SumW + 1);
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  typedef struct packed {
    logic              flush;
    logic [ShellW-1:0] shell;
    logic [PowW-1:0]   power;
  } entry_t;

  // Wraps an index into the grid and folds it onto 0..HalfN.
  function automatic logic [FoldW-1:0] fold_index(input logic [IdxW-1:0] v);
    logic [FoldW-1:0] r;
    r = '0;
    for (int n = 0; n < (1 << IdxW); n++) begin
      if (v == IdxW'(n)) begin
        r = FoldW'(HalfN - (((n % GridSize) >= HalfN) ? ((n % GridSize) - HalfN)
                                                     : (HalfN - (n % GridSize))));
      end
    end
    return r;
  endfunction

  // Largest shell b with 3*b*b not above the squared magnitude.
  function automatic logic [ShellW-1:0] shell_of(input logic [MagW-1:0] m);
    logic [ShellW-1:0] b;
    b = '0;
    for (int n = 1; n <= HalfN; n++) begin
      if (MagW'(3 * n * n) <= m) begin
        b = ShellW'(n);
      end
    end
    return b;
  endfunction
endpackage
`default_nettype wire

[rtl/ipsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ipsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/ipsb_front.sv]
// Front end: accepts modes and flush requests, folds indices, squares the value and picks the shell.
`default_nettype none
module ipsb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic [5:0]                    index_i_i,
  input  wire logic [5:0]                    index_j_i,
  input  wire logic [5:0]                    index_k_i,
  input  wire logic signed [15:0]            real_part_i,
  input  wire logic signed [15:0]            imag_part_i,
  output logic                               push_o,
  output ipsb_pkg::entry_t                   entry_o,
  input  wire logic                          full_i
);
  logic                            valid_q, valid_d;
  logic                            flush_q;
  logic                            dbl_q;
  logic [ipsb_pkg::FoldW-1:0]      i_q, j_q, k_q;
  logic [ipsb_pkg::SqW-1:0]        re_sq_q, im_sq_q;
  logic                            take;
  logic [ipsb_pkg::MagW-1:0]       mag;
  logic [ipsb_pkg::PowW-1:0]       pow_raw;
  logic signed [31:0]              re_sq, im_sq;

  assign in_ready_o = !valid_q || !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? (mode_i || (index_i_i <= ipsb_pkg::IdxW'(ipsb_pkg::HalfN)))
                           : (valid_q && full_i);
  assign re_sq      = real_part_i * real_part_i;
  assign im_sq      = imag_part_i * imag_part_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flush_q <= mode_i;
      dbl_q   <= (index_i_i != '0) && (index_i_i != ipsb_pkg::IdxW'(ipsb_pkg::HalfN));
      i_q     <= ipsb_pkg::FoldW'(index_i_i);
      j_q     <= ipsb_pkg::fold_index(index_j_i);
      k_q     <= ipsb_pkg::fold_index(index_k_i);
      re_sq_q <= re_sq[ipsb_pkg::SqW-1:0];
      im_sq_q <= im_sq[ipsb_pkg::SqW-1:0];
    end
  end

  assign mag = ipsb_pkg::MagW'(i_q * i_q) + ipsb_pkg::MagW'(j_q * j_q)
             + ipsb_pkg::MagW'(k_q * k_q);
  assign pow_raw = ipsb_pkg::PowW'(re_sq_q) + ipsb_pkg::PowW'(im_sq_q);

  assign push_o        = valid_q && !full_i;
  assign entry_o.flush = flush_q;
  assign entry_o.shell = ipsb_pkg::shell_of(mag);
  assign entry_o.power = dbl_q ? (pow_raw << 1) : pow_raw;
endmodule
`default_nettype wire

[rtl/ipsb_fifo.sv]
// Short queue of classified requests between the front and back ends.
`default_nettype none
module ipsb_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ipsb_pkg::entry_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output ipsb_pkg::entry_t      data_o
);
  ipsb_pkg::entry_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 2'd1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

[rtl/ipsb_back.sv]
// Back end: shell bins, read-modify-write accumulation and the averaging flush.
`default_nettype none
module ipsb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire ipsb_pkg::entry_t              q_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ipsb_pkg::OutShW-1:0]        shell_index_o,
  output logic [ipsb_pkg::MeanW-1:0]         mean_power_o,
  output logic [ipsb_pkg::CntW-1:0]          mode_count_o,
  output logic                               last_o
);
  typedef enum logic [2:0] {StIdle, StAcc, StFlData, StDiv, StEmit} state_e;

  state_e                          state_q;
  logic [ipsb_pkg::NumShells-1:0]  vld_q;
  logic [ipsb_pkg::ShellW-1:0]     sh_q;
  logic [ipsb_pkg::PowW-1:0]       pow_q;
  logic [ipsb_pkg::SumW-1:0]       quo_q;
  logic [ipsb_pkg::CntW:0]         rem_q;
  logic [ipsb_pkg::CntW-1:0]       cnt_q;
  logic [ipsb_pkg::DivCntW-1:0]    div_q;
  logic [ipsb_pkg::ShellW-1:0]     raddr;
  logic [ipsb_pkg::BinW-1:0]       rdata, wdata;
  logic [ipsb_pkg::SumW-1:0]       bin_sum;
  logic [ipsb_pkg::CntW-1:0]       bin_cnt;
  logic                            we;
  logic [ipsb_pkg::CntW+1:0]       trial;
  logic                            slot_free;

  ipsb_ram #(.Width(ipsb_pkg::BinW), .Depth(ipsb_pkg::NumShells)) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (sh_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign bin_sum   = vld_q[sh_q] ? rdata[ipsb_pkg::BinW-1:ipsb_pkg::CntW] : '0;
  assign bin_cnt   = vld_q[sh_q] ? rdata[ipsb_pkg::CntW-1:0] : '0;
  assign we        = (state_q == StAcc) && (bin_cnt != ipsb_pkg::CountMax);
  assign wdata     = {bin_sum + ipsb_pkg::SumW'(pow_q), bin_cnt + ipsb_pkg::CntW'(1)};
  assign pop_o     = (state_q == StIdle) && q_valid_i;
  assign raddr     = (state_q == StIdle) ? (q_data_i.flush ? '0 : q_data_i.shell)
                                         : sh_q + ipsb_pkg::ShellW'(1);
  assign trial     = {rem_q, quo_q[ipsb_pkg::SumW-1]} - {2'b00, cnt_q};
  assign slot_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !((state_q == StEmit) && slot_free)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            sh_q    <= q_data_i.flush ? '0 : q_data_i.shell;
            pow_q   <= q_data_i.power;
            state_q <= q_data_i.flush ? StFlData : StAcc;
          end
        end
        StAcc: begin
          if (we) begin
            vld_q[sh_q] <= 1'b1;
          end
          state_q <= StIdle;
        end
        StFlData: begin
          cnt_q   <= bin_cnt;
          quo_q   <= bin_sum;
          rem_q   <= '0;
          div_q   <= ipsb_pkg::DivCntW'(ipsb_pkg::SumW);
          state_q <= (bin_cnt == '0) ? StEmit : StDiv;
          if (bin_cnt == '0) begin
            quo_q <= '0;
          end
        end
        StDiv: begin
          if (!trial[ipsb_pkg::CntW+1]) begin
            rem_q <= trial[ipsb_pkg::CntW:0];
          end else begin
            rem_q <= {rem_q[ipsb_pkg::CntW-1:0], quo_q[ipsb_pkg::SumW-1]};
          end
          quo_q <= {quo_q[ipsb_pkg::SumW-2:0], !trial[ipsb_pkg::CntW+1]};
          div_q <= div_q - ipsb_pkg::DivCntW'(1);
          if (div_q == ipsb_pkg::DivCntW'(1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (slot_free) begin
            out_valid_o   <= 1'b1;
            shell_index_o <= ipsb_pkg::OutShW'(sh_q);
            mean_power_o  <= quo_q[ipsb_pkg::MeanW-1:0];
            mode_count_o  <= cnt_q;
            last_o        <= sh_q == ipsb_pkg::ShellW'(ipsb_pkg::ReportN - 1);
            if (sh_q == ipsb_pkg::ShellW'(ipsb_pkg::ReportN - 1)) begin
              vld_q   <= '0;
              state_q <= StIdle;
            end else begin
              sh_q    <= sh_q + ipsb_pkg::ShellW'(1);
              state_q <= StFlData;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/isotropic_power_spectrum_binner.sv]
// Top level of the isotropic power spectrum binner.
//
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid_i/in_ready_o | mode, index_i/j/k, real_part, imag_part
// output  | out       | out_valid_o/out_ready_i | shell_index, mean_power, mode_count, last
//
// An accumulate request occupies the bin back end for a bin RAM read, then a write.
// A flush runs the one-bit-per-cycle divider for each reported shell that holds modes,
// skips it for an empty shell, and emits one result per reported shell.
// The front end keeps accepting into a 4-entry queue while the back end works.
// Reset clears all bins at once through per-shell valid bits; no clearing pass is needed.
// A stalled output holds its result while the next shell is divided behind it.
`default_nettype none
module isotropic_power_spectrum_binner (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                mode_i,
  input  wire logic [5:0]          index_i_i,
  input  wire logic [5:0]          index_j_i,
  input  wire logic [5:0]          index_k_i,
  input  wire logic signed [15:0]  real_part_i,
  input  wire logic signed [15:0]  imag_part_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [4:0]               shell_index_o,
  output logic [32:0]              mean_power_o,
  output logic [18:0]              mode_count_o,
  output logic                     last_o
);
  logic             push, full, pop, q_valid;
  ipsb_pkg::entry_t push_data, q_data;

  ipsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .index_i_i   (index_i_i),
    .index_j_i   (index_j_i),
    .index_k_i   (index_k_i),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .push_o      (push),
    .entry_o     (push_data),
    .full_i      (full)
  );

  ipsb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  ipsb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .shell_index_o (shell_index_o),
    .mean_power_o  (mean_power_o),
    .mode_count_o  (mode_count_o),
    .last_o        (last_o)
  );
endmodule
`default_nettype wire

[rtl/ipsb_checker.sv]
// Port-level checker for the binner, bound to the top level.
`default_nettype none
module ipsb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  shell_index_o,
  input wire logic [32:0] mean_power_o,
  input wire logic [18:0] mode_count_o,
  input wire logic        last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(shell_index_o)
      && $stable(mean_power_o) && $stable(mode_count_o) && $stable(last_o))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_count_o == '0) |-> mean_power_o == '0)
    else $error("empty shell with nonzero mean");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> shell_index_o == 5'(ipsb_pkg::ReportN - 1))
    else $error("last flag on wrong shell");

  a_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_count_o == 19'd1) |-> mean_power_o[32:31] != 2'b11)
    else $error("single mode mean out of range");
endmodule

bind isotropic_power_spectrum_binner ipsb_checker u_ipsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .shell_index_o (shell_index_o),
  .mean_power_o  (mean_power_o),
  .mode_count_o  (mode_count_o),
  .last_o        (last_o)
);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the isotropic power spectrum binner, with a shell-binning predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        flush;
    logic [5:0]  idx_i;
    logic [5:0]  idx_j;
    logic [5:0]  idx_k;
    logic [15:0] re;
    logic [15:0] im;
    logic        drain_first;
  } request_t;

  typedef struct {
    logic [4:0]  shell;
    logic [32:0] mean;
    logic [18:0] count;
    logic        last;
  } shell_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic [5:0] index_i_i = '0, index_j_i = '0, index_k_i = '0;
  logic signed [15:0] real_part_i = '0, imag_part_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [4:0] shell_index_o;
  logic [32:0] mean_power_o;
  logic [18:0] mode_count_o;
  logic last_o;

  request_t pending_requests[$];
  shell_report_t expected_reports[$];
  logic [ipsb_pkg::SumW-1:0] power_sum[ipsb_pkg::NumShells];
  logic [ipsb_pkg::CntW-1:0] mode_total[ipsb_pkg::NumShells];
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  int unsigned flushes_sent = 0;
  int unsigned modes_sent = 0;
  int unsigned hold_left = 0;
  bit long_hold_done = 0;

  isotropic_power_spectrum_binner uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned folded(input logic [5:0] v);
    int unsigned w;
    w = v % ipsb_pkg::GridSize;
    return (w >= ipsb_pkg::HalfN) ? ipsb_pkg::HalfN - (w - ipsb_pkg::HalfN) : w;
  endfunction

  function automatic int unsigned shell_for(input int unsigned m);
    int unsigned b;
    b = 0;
    while (b < ipsb_pkg::HalfN && 3 * (b + 1) * (b + 1) <= m) b++;
    return b;
  endfunction

  task automatic clear_shells();
    for (int s = 0; s < ipsb_pkg::NumShells; s++) begin
      power_sum[s] = '0;
      mode_total[s] = '0;
    end
  endtask

  task automatic predict_request(input request_t r);
    int unsigned ii, jj, kk, b;
    longint signed re, im;
    logic [ipsb_pkg::SumW-1:0] pw;
    shell_report_t rep;
    if (r.flush) begin
      for (int s = 0; s < ipsb_pkg::ReportN; s++) begin
        rep.shell = s[4:0];
        rep.count = mode_total[s];
        rep.mean = (mode_total[s] == 0) ? '0 : 33'(power_sum[s] / mode_total[s]);
        rep.last = (s == ipsb_pkg::ReportN - 1);
        expected_reports = {expected_reports, rep};
      end
      clear_shells();
    end else begin
      ii = r.idx_i;
      if (ii > ipsb_pkg::HalfN) return;
      jj = folded(r.idx_j);
      kk = folded(r.idx_k);
      b = shell_for(ii * ii + jj * jj + kk * kk);
      re = $signed(r.re);
      im = $signed(r.im);
      pw = ipsb_pkg::SumW'(re * re + im * im);
      if (ii != 0 && ii != ipsb_pkg::HalfN) pw = pw << 1;
      if (mode_total[b] < ipsb_pkg::CountMax) begin
        mode_total[b] = mode_total[b] + 1'b1;
        power_sum[b] = power_sum[b] + pw;
      end
    end
  endtask

  function automatic bit idle_now();
    if (cycle_count >= 1500 && cycle_count < 4000) return 0;
    return $urandom_range(99) < 14;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t nx, cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.flush = mode_i;
        cur.idx_i = index_i_i;
        cur.idx_j = index_j_i;
        cur.idx_k = index_k_i;
        cur.re = real_part_i;
        cur.im = imag_part_i;
        predict_request(cur);
        if (mode_i) flushes_sent++; else modes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() > 0 &&
            !(pending_requests[0].drain_first && expected_reports.size() > 0) &&
            !idle_now()) begin
          nx = pending_requests.pop_front();
          mode_i <= nx.flush;
          index_i_i <= nx.idx_i;
          index_j_i <= nx.idx_j;
          index_k_i <= nx.idx_k;
          real_part_i <= nx.re;
          imag_part_i <= nx.im;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off for a long stretch once the second flush starts reporting.
  always @(posedge clk_i) begin
    if (!long_hold_done && reports_seen == ipsb_pkg::ReportN + 2) begin
      hold_left <= 600;
      long_hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_reports
    shell_report_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("Unexpected shell report for shell %0d", shell_index_o);
          mismatches++;
        end else begin
          e = expected_reports.pop_front();
          if (shell_index_o !== e.shell) begin
            $error("shell_index expected %0d got %0d", e.shell, shell_index_o);
            mismatches++;
          end
          if (mean_power_o !== e.mean) begin
            $error("mean_power expected %0d got %0d", e.mean, mean_power_o);
            mismatches++;
          end
          if (mode_count_o !== e.count) begin
            $error("mode_count expected %0d got %0d", e.count, mode_count_o);
            mismatches++;
          end
          if (last_o !== e.last) begin
            $error("last expected %0d got %0d", e.last, last_o);
            mismatches++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && !idle_now();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Timed out with %0d shell reports outstanding", expected_reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_request(input logic f, input logic [5:0] a, input logic [5:0] b,
                             input logic [5:0] c, input logic [15:0] re,
                             input logic [15:0] im, input logic drain);
    request_t r;
    r.flush = f;
    r.idx_i = a;
    r.idx_j = b;
    r.idx_k = c;
    r.re = re;
    r.im = im;
    r.drain_first = drain;
    pending_requests = {pending_requests, r};
  endtask

  initial begin
    clear_shells();
    // Extremes of indices and values, dropped modes and an empty-shell flush.
    add_request(0, 0, 0, 0, 16'h8000, 16'h8000, 0);
    add_request(0, 32, 32, 32, 16'h7fff, 16'h7fff, 0);
    add_request(0, 1, 63, 33, 16'h8000, 16'h7fff, 0);
    add_request(0, 31, 31, 1, 16'hffff, 16'h0001, 0);
    add_request(0, 33, 5, 5, 16'h1234, 16'h4321, 0);
    add_request(0, 63, 63, 63, 16'h7fff, 16'h8000, 0);
    add_request(0, 0, 32, 0, 16'h0000, 16'h0000, 0);
    add_request(0, 16, 48, 16, 16'h5555, 16'haaaa, 0);
    add_request(0, 2, 1, 62, 16'h00ff, 16'hff00, 0);
    add_request(1, 63, 63, 63, 16'hffff, 16'hffff, 0);
    add_request(1, 0, 0, 0, 16'h0000, 16'h0000, 0);
    for (int n = 0; n < 200; n++) begin
      if (n % 22 == 21) begin
        add_request(1, $urandom, $urandom, $urandom, $urandom, $urandom, n == 109);
      end else if ($urandom_range(19) == 0) begin
        add_request(0, $urandom_range(63, 33), $urandom, $urandom, $urandom, $urandom, 0);
      end else begin
        add_request(0, $urandom_range(32), $urandom, $urandom, $urandom, $urandom, 0);
      end
    end
    add_request(1, 0, 0, 0, 16'h0000, 16'h0000, 0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_requests.size() == 0 && !in_valid_i && expected_reports.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d modes and %0d flushes; checked %0d shell reports.",
             modes_sent, flushes_sent, reports_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/ipsb_pkg.sv
rtl/ipsb_ram.sv
rtl/ipsb_front.sv
rtl/ipsb_fifo.sv
rtl/ipsb_back.sv
rtl/isotropic_power_spectrum_binner.sv
rtl/ipsb_checker.sv
tb/testbench.sv
